[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL in this folder.
// Each macro expects aclk in scope; PLQ_ASSERT also expects aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define PLQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included
`define PLQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/plq_pkg.sv]
// ----------------------------------------------------------------------------
// plq_pkg
// Types and codes of the priority load task queue: operation codes, task
// kind bits and the packed descriptor held in the slot memory.
// ----------------------------------------------------------------------------
`default_nettype none

package plq_pkg;

    // Input operation codes
    localparam logic [1:0] OP_APPEND_SEG = 2'd0;
    localparam logic [1:0] OP_APPEND_DMA = 2'd1;
    localparam logic [1:0] OP_PROCESS    = 2'd2;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One stored descriptor; kind is {is_dma, compressed}
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  segment;
        logic [31:0] source_start;
        logic [31:0] source_end;
        logic        side;
        logic [31:0] dest_start;
        logic [31:0] bss_end;
        logic [7:0]  priority_lvl;
    } slot_t;

endpackage

`default_nettype wire

[rtl/core/priority_load_task_queue_top.sv]
// An append, a process on an empty table or an unused operation gives a
// result beat via ST_RESP; s_ready returns once it is in the output register.
// A process with N stored tasks scans all N slots over the slot memory read
// port for each task, then loads that task into the output register.
// Reset clears the fill count, slot valid bits and handshake state; the slot
// memory itself is not cleared, the fill count bounds every read.
// ----------------------------------------------------------------------------
// priority_load_task_queue_top
// Table of load-task descriptors in one synchronous memory. Appends go to
// the next free slot; a process beat drains the table in priority order,
// scanning the memory once per dispatched task.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module priority_load_task_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [4:0]  s_segment_number,
    input  wire logic [31:0] s_source_start,
    input  wire logic [31:0] s_source_end,
    input  wire logic        s_pool_side,
    input  wire logic [7:0]  s_task_priority,
    input  wire logic [31:0] s_dest_or_bss_start,
    input  wire logic [31:0] s_bss_end,
    input  wire logic [7:0]  s_compressed_flag,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic             m_task_valid,
    output logic [1:0]       m_task_kind,
    output logic [4:0]       m_out_segment,
    output logic [31:0]      m_out_source_start,
    output logic [31:0]      m_out_source_end,
    output logic             m_out_side,
    output logic [31:0]      m_out_dest_or_bss_start,
    output logic [31:0]      m_out_bss_end,
    output logic [7:0]       m_out_priority,
    output logic             m_last
);

    import plq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       entry_count_reg;
    logic [QUEUE_DEPTH-1:0] slot_valid_reg;
    logic                   resp_status_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       issue_reg;
    logic                   rd_pend_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    slot_t                  best_reg;
    slot_t                  rd_data_reg;
    logic                   m_valid_reg;
    logic                   m_status_reg;
    logic                   m_task_valid_reg;
    logic                   m_last_reg;
    slot_t                  m_slot_reg;

    slot_t                  slot_mem [QUEUE_DEPTH];

    logic                   s_beat;
    logic                   is_append;
    logic                   queue_full;
    logic                   mem_we;
    slot_t                  mem_wdata;
    logic [IDX_W-1:0]       rd_addr;
    logic                   scan_issue;
    logic                   out_free;
    logic                   out_load;
    logic                   take_best;
    logic [CNT_W-1:0]       valid_ones;
    logic                   last_emit;

    // Handshake and control decode
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_beat     = s_valid && s_ready;
    assign is_append  = (s_operation == OP_APPEND_SEG) || (s_operation == OP_APPEND_DMA);
    assign queue_full = (entry_count_reg >= DEPTH_CNT);
    assign mem_we     = s_beat && is_append && !queue_full;
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = ((state_reg == ST_RESP) || (state_reg == ST_EMIT)) && out_free;
    assign scan_issue = (state_reg == ST_SCAN) && (issue_reg < entry_count_reg);
    assign rd_addr    = issue_reg[IDX_W-1:0];
    assign take_best  = rd_pend_reg && slot_valid_reg[rd_idx_reg] &&
                        (!found_reg || (rd_data_reg.priority_lvl > best_reg.priority_lvl));

    // Descriptor built from the input beat; DMA tasks drop segment fields
    always_comb begin
        mem_wdata              = '0;
        mem_wdata.kind         = {(s_operation == OP_APPEND_DMA), (|s_compressed_flag)};
        mem_wdata.source_start = s_source_start;
        mem_wdata.source_end   = s_source_end;
        mem_wdata.dest_start   = s_dest_or_bss_start;
        mem_wdata.priority_lvl = s_task_priority;
        if (s_operation == OP_APPEND_SEG) begin
            mem_wdata.segment = s_segment_number;
            mem_wdata.side    = s_pool_side;
            mem_wdata.bss_end = s_bss_end;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[entry_count_reg[IDX_W-1:0]] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    // Main sequencer with output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            slot_valid_reg  <= '0;
            rd_pend_reg     <= 1'b0;
            found_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_pend_reg <= scan_issue;
            rd_idx_reg  <= rd_addr;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_beat) begin
                        if (is_append) begin
                            state_reg <= ST_RESP;
                            if (queue_full) begin
                                resp_status_reg <= STATUS_FULL;
                            end else begin
                                resp_status_reg <= STATUS_OK;
                                slot_valid_reg[entry_count_reg[IDX_W-1:0]] <= 1'b1;
                                entry_count_reg <= entry_count_reg + ONE_CNT;
                            end
                        end else if (s_operation == OP_PROCESS &&
                                     entry_count_reg != '0) begin
                            rem_reg   <= entry_count_reg;
                            issue_reg <= '0;
                            found_reg <= 1'b0;
                            state_reg <= ST_SCAN;
                        end else begin
                            resp_status_reg <= STATUS_OK;
                            state_reg       <= ST_RESP;
                        end
                    end
                end

                ST_RESP: begin
                    if (out_free) begin
                        m_status_reg     <= resp_status_reg;
                        m_task_valid_reg <= 1'b0;
                        m_slot_reg       <= '0;
                        m_last_reg       <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end

                ST_SCAN: begin
                    if (scan_issue) begin
                        issue_reg <= issue_reg + ONE_CNT;
                    end
                    // strict compare keeps the lowest slot on equal priority
                    if (take_best) begin
                        best_reg     <= rd_data_reg;
                        best_idx_reg <= rd_idx_reg;
                        found_reg    <= 1'b1;
                    end
                    if (!scan_issue && !rd_pend_reg) begin
                        state_reg <= ST_EMIT;
                    end
                end

                ST_EMIT: begin
                    if (out_free) begin
                        m_status_reg     <= STATUS_OK;
                        m_task_valid_reg <= 1'b1;
                        m_slot_reg       <= best_reg;
                        m_last_reg       <= (rem_reg == ONE_CNT);
                        slot_valid_reg[best_idx_reg] <= 1'b0;
                        rem_reg          <= rem_reg - ONE_CNT;
                        if (rem_reg == ONE_CNT) begin
                            entry_count_reg <= '0;
                            state_reg       <= ST_IDLE;
                        end else begin
                            issue_reg <= '0;
                            found_reg <= 1'b0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output ports
    assign m_valid                 = m_valid_reg;
    assign m_status                = m_status_reg;
    assign m_task_valid            = m_task_valid_reg;
    assign m_task_kind             = m_slot_reg.kind;
    assign m_out_segment           = m_slot_reg.segment;
    assign m_out_source_start      = m_slot_reg.source_start;
    assign m_out_source_end        = m_slot_reg.source_end;
    assign m_out_side              = m_slot_reg.side;
    assign m_out_dest_or_bss_start = m_slot_reg.dest_start;
    assign m_out_bss_end           = m_slot_reg.bss_end;
    assign m_out_priority          = m_slot_reg.priority_lvl;
    assign m_last                  = m_last_reg;

    // Checks
    assign valid_ones = CNT_W'($countones(slot_valid_reg));
    assign last_emit  = (state_reg == ST_EMIT) && out_free && (rem_reg == ONE_CNT);

    `PLQ_ASSERT(a_count_bound, (entry_count_reg <= DEPTH_CNT), "fill count above depth")
    `PLQ_ASSERT(a_idle_valid_match, (s_ready |-> (valid_ones == entry_count_reg)), "bad valid bits")
    `PLQ_ASSERT(a_scan_remaining, (scan_issue |-> (valid_ones == rem_reg)), "bad scan count")
    `PLQ_ASSERT(a_drain_done, (last_emit |=> (s_ready && entry_count_reg == '0)), "drain not closed")

endmodule

`default_nettype wire
